// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the band peak meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted (active low).
`define BPHM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: %s failed", "lbl");
// Clocked assertion that also holds during reset.
`define BPHM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: %s failed", "lbl");
`else
`define BPHM_ASSERT(lbl, clk, rst_n, prop)
`define BPHM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/bphm_pkg.sv =====
// Package: constants, types and helpers of the band peak meter.
package bphm_pkg;

    localparam int NUM_BANDS  = 16;
    localparam int BAND_IDX_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    localparam int BAND_W   = 6;
    localparam int LEVEL_W  = 16;
    localparam int HOLD_W   = 8;
    localparam int FALL_W   = 16;
    localparam int BOX_X_W  = 15;
    localparam int TOP_W    = 13;
    localparam int HEIGHT_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Level scale: 100 is full scale.
    localparam int FULL_SCALE = 100;
    localparam int CLAMP_W    = 7;
    localparam int PROD_W     = HEIGHT_W + CLAMP_W;
    // x / 100 == (x * RECIP_K) >> RECIP_SHIFT, exact for x < 199728.
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_K     = (2 ** RECIP_SHIFT + FULL_SCALE - 1) / FULL_SCALE;
    localparam int RECIP_W     = 18;
    localparam int MUL_W       = PROD_W + RECIP_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PRINT_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_PITCH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_HEIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MARKER_HEIGHT = 3'd7;

    // Print modes; code three draws like PM_ALL.
    localparam logic [1:0] PM_NONE = 2'd0;
    localparam logic [1:0] PM_BARS = 2'd1;
    localparam logic [1:0] PM_ALL  = 2'd2;

    typedef struct packed {
        logic [1:0]            print_mode;
        logic [HOLD_W-1:0]     hold_time;
        logic [7:0]            gravity;
        logic [11:0]           origin_x;
        logic [11:0]           baseline_y;
        logic [7:0]            band_pitch;
        logic [HEIGHT_W-1:0]   full_height;
        logic [7:0]            marker_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        print_mode:    PM_ALL,
        hold_time:     8'd15,
        gravity:       8'd1,
        origin_x:      12'd0,
        baseline_y:    12'd600,
        band_pitch:    8'd5,
        full_height:   10'd60,
        marker_height: 8'd2
    };

    // Stage-1 payload leaving the tracker.
    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic               in_range;
        logic [CLAMP_W-1:0] lvl_c;
        logic [CLAMP_W-1:0] pk_c;
        logic [LEVEL_W-1:0] peak;
    } t_trk;

    // Result transaction.
    typedef struct packed {
        logic [BAND_W-1:0]          band_out;
        logic [BOX_X_W-1:0]         box_x;
        logic signed [TOP_W-1:0]    bar_top;
        logic [HEIGHT_W-1:0]        bar_height;
        logic signed [TOP_W-1:0]    marker_top;
        logic [LEVEL_W-1:0]         peak_level;
        logic                       draw_bar;
        logic                       draw_marker;
    } t_res;

    function automatic logic [CLAMP_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
        logic [CLAMP_W-1:0] r;
        if (v > LEVEL_W'(FULL_SCALE)) begin
            r = CLAMP_W'(FULL_SCALE);
        end else begin
            r = v[CLAMP_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bphm_track.sv =====
// Per-band peak/hold/fall stores and the first pipeline stage.
module bphm_track (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bphm_pkg::t_cfg                i_cfg,
    input  logic                          i_vld,
    input  logic [bphm_pkg::BAND_W-1:0]   i_band,
    input  logic [bphm_pkg::LEVEL_W-1:0]  i_level,
    output logic                          o_ready,
    input  logic                          i_nxt_ready,
    output logic                          o_vld,
    output bphm_pkg::t_trk                o_trk
);

    logic [bphm_pkg::LEVEL_W-1:0] r_peak [bphm_pkg::NUM_BANDS];
    logic [bphm_pkg::HOLD_W-1:0]  r_hold [bphm_pkg::NUM_BANDS];
    logic [bphm_pkg::FALL_W-1:0]  r_fall [bphm_pkg::NUM_BANDS];

    logic                  r_vld;
    bphm_pkg::t_trk        r_trk;

    logic [bphm_pkg::BAND_IDX_W-1:0] idx;
    logic                  in_range;
    logic                  en;
    logic                  take;
    logic [bphm_pkg::LEVEL_W-1:0] pk_a;
    logic [bphm_pkg::HOLD_W-1:0]  hold_a;
    logic [bphm_pkg::FALL_W-1:0]  fall_a;
    logic [bphm_pkg::LEVEL_W:0]   floor_sum;
    logic [bphm_pkg::FALL_W:0]    fall_inc;
    logic [bphm_pkg::LEVEL_W-1:0] n_peak;
    logic [bphm_pkg::HOLD_W-1:0]  n_hold;
    logic [bphm_pkg::FALL_W-1:0]  n_fall;
    logic [bphm_pkg::LEVEL_W-1:0] peak_out;
    bphm_pkg::t_trk        n_trk;

    assign idx      = i_band[bphm_pkg::BAND_IDX_W-1:0];
    assign in_range = {1'b0, i_band} < (bphm_pkg::BAND_W + 1)'(bphm_pkg::NUM_BANDS);
    assign en       = !r_vld || i_nxt_ready;
    assign take     = i_vld && en;
    assign o_ready  = en;

    // New peak capture.
    always_comb begin
        if (i_level > r_peak[idx]) begin
            pk_a   = i_level;
            hold_a = i_cfg.hold_time;
            fall_a = '0;
        end else begin
            pk_a   = r_peak[idx];
            hold_a = r_hold[idx];
            fall_a = r_fall[idx];
        end
    end

    assign floor_sum = {1'b0, fall_a} + {1'b0, i_level};
    assign fall_inc  = {1'b0, fall_a} + (bphm_pkg::FALL_W + 1)'(i_cfg.gravity);

    // Hold countdown, then gravity fall; snap to level if it would undershoot.
    always_comb begin
        if (hold_a != '0) begin
            n_peak = pk_a;
            n_hold = hold_a - 1'b1;
            n_fall = fall_a;
        end else if ({1'b0, pk_a} < floor_sum) begin
            n_peak = i_level;
            n_hold = i_cfg.hold_time;
            n_fall = '0;
        end else begin
            n_peak = pk_a - fall_a;
            n_hold = hold_a;
            n_fall = fall_inc[bphm_pkg::FALL_W] ? '1 : fall_inc[bphm_pkg::FALL_W-1:0];
        end
    end

    assign peak_out = in_range ? n_peak : '0;

    always_comb begin
        n_trk.band     = i_band;
        n_trk.in_range = in_range;
        n_trk.lvl_c    = bphm_pkg::clamp_level(i_level);
        n_trk.pk_c     = bphm_pkg::clamp_level(peak_out);
        n_trk.peak     = peak_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bphm_pkg::NUM_BANDS; i++) begin
                r_peak[i] <= '0;
                r_hold[i] <= '0;
                r_fall[i] <= '0;
            end
        end else if (take && in_range) begin
            r_peak[idx] <= n_peak;
            r_hold[idx] <= n_hold;
            r_fall[idx] <= n_fall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_trk <= n_trk;
        end
    end

    assign o_vld = r_vld;
    assign o_trk = r_trk;

endmodule

// ===== hw/rtl/bphm_geom.sv =====
// Geometry stages: scale products, divide by full scale, box coordinates.
module bphm_geom (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bphm_pkg::t_cfg  i_cfg,
    input  logic            i_vld,
    input  bphm_pkg::t_trk  i_trk,
    output logic            o_ready,
    input  logic            i_out_ready,
    output logic            o_vld,
    output bphm_pkg::t_res  o_res
);

    // Stage 2: products.
    logic                                r_vld2;
    logic [bphm_pkg::BAND_W-1:0]         r_band2;
    logic                                r_in2;
    logic [bphm_pkg::LEVEL_W-1:0]        r_peak2;
    logic [bphm_pkg::PROD_W-1:0]         r_bar_prod;
    logic [bphm_pkg::PROD_W-1:0]         r_mk_prod;
    logic [bphm_pkg::BOX_X_W-1:0]        r_box_x2;
    // Stage 3: divided heights.
    logic                                r_vld3;
    logic [bphm_pkg::BAND_W-1:0]         r_band3;
    logic                                r_in3;
    logic [bphm_pkg::LEVEL_W-1:0]        r_peak3;
    logic [bphm_pkg::BOX_X_W-1:0]        r_box_x3;
    logic [bphm_pkg::HEIGHT_W-1:0]       r_bar_h;
    logic [bphm_pkg::HEIGHT_W-1:0]       r_mk_h;
    // Stage 4: output register.
    logic                                r_vld4;
    bphm_pkg::t_res                      r_res;

    logic en2, en3, en4;
    logic [bphm_pkg::MUL_W-1:0] bar_mul;
    logic [bphm_pkg::MUL_W-1:0] mk_mul;
    bphm_pkg::t_res             n_res;

    assign en4     = !r_vld4 || i_out_ready;
    assign en3     = !r_vld3 || en4;
    assign en2     = !r_vld2 || en3;
    assign o_ready = en2;

    assign bar_mul = bphm_pkg::MUL_W'(r_bar_prod) * bphm_pkg::MUL_W'(bphm_pkg::RECIP_K);
    assign mk_mul  = bphm_pkg::MUL_W'(r_mk_prod) * bphm_pkg::MUL_W'(bphm_pkg::RECIP_K);

    always_comb begin
        n_res.band_out    = r_band3;
        n_res.box_x       = r_box_x3;
        n_res.bar_height  = r_bar_h;
        n_res.bar_top     = $signed({1'b0, i_cfg.baseline_y})
                          - $signed({3'b000, r_bar_h});
        n_res.marker_top  = $signed({1'b0, i_cfg.baseline_y})
                          - $signed({3'b000, r_mk_h})
                          - $signed({5'b00000, i_cfg.marker_height});
        n_res.peak_level  = r_peak3;
        n_res.draw_bar    = r_in3 && (i_cfg.print_mode >= bphm_pkg::PM_BARS);
        n_res.draw_marker = r_in3 && (i_cfg.print_mode >= bphm_pkg::PM_ALL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en2) begin
                r_vld2 <= i_vld;
            end
            if (en3) begin
                r_vld3 <= r_vld2;
            end
            if (en4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_band2    <= i_trk.band;
            r_in2      <= i_trk.in_range;
            r_peak2    <= i_trk.peak;
            r_bar_prod <= bphm_pkg::PROD_W'(i_cfg.full_height) * bphm_pkg::PROD_W'(i_trk.lvl_c);
            r_mk_prod  <= bphm_pkg::PROD_W'(i_cfg.full_height) * bphm_pkg::PROD_W'(i_trk.pk_c);
            r_box_x2   <= bphm_pkg::BOX_X_W'(i_cfg.origin_x)
                        + bphm_pkg::BOX_X_W'(i_cfg.band_pitch) * bphm_pkg::BOX_X_W'(i_trk.band);
        end
        if (en3) begin
            r_band3  <= r_band2;
            r_in3    <= r_in2;
            r_peak3  <= r_peak2;
            r_box_x3 <= r_box_x2;
            r_bar_h  <= bar_mul[bphm_pkg::RECIP_SHIFT +: bphm_pkg::HEIGHT_W];
            r_mk_h   <= mk_mul[bphm_pkg::RECIP_SHIFT +: bphm_pkg::HEIGHT_W];
        end
        if (en4) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld4;
    assign o_res = r_res;

endmodule

// ===== hw/rtl/band_peak_hold_meter.sv =====
// Top level of the band peak meter: config registers, pipeline, stream ports.
//
// Spectrum bar meter with per-band peak hold and gravity fall. Each input
// transaction carries one band's level; each produces exactly one result
// transaction with the bar box, the peak-marker box and the held peak.
// Throughput is one transaction per clock while the result side keeps up.
// There are four register stages (tracker stage, product stage, divide
// stage, output register), passed in that order. The per-band peak, hold
// and fall-speed stores sit in flip-flops and are read, updated and
// written back in the accept cycle, so the same band may arrive on
// consecutive cycles. Backpressure on the master side stalls the whole
// pipeline without loss; s_axis_tready stays high whenever any stage is
// free. Bands at or above NUM_BANDS leave the stores untouched and report
// a zero peak with both draw flags low. Configuration is a write-only port
// (index 0..7 in the order print_mode, hold_time, gravity, origin_x,
// baseline_y, band_pitch, full_height, marker_height) and should only be
// written while the pipeline is empty.
`include "assert_macros.svh"

module band_peak_hold_meter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic [bphm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bphm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [23:0]                        s_axis_tdata,  // band[5:0], level[21:6], zero pad
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // band_out[5:0], box_x[20:6], bar_top[33:21], bar_height[43:34],
    // marker_top[56:44], peak_level[72:57], zero pad[79:73]
    output logic [79:0]                        m_axis_tdata,
    output logic [1:0]                         m_axis_tuser   // draw_bar[0], draw_marker[1]
);

    bphm_pkg::t_cfg r_cfg;

    logic           trk_vld;
    bphm_pkg::t_trk trk;
    logic           geom_ready;
    bphm_pkg::t_res res;

    // Config registers; to be written only while idle, which the block itself does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bphm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bphm_pkg::REG_PRINT_MODE:    r_cfg.print_mode    <= i_cfg_data[1:0];
                bphm_pkg::REG_HOLD_TIME:     r_cfg.hold_time     <= i_cfg_data[7:0];
                bphm_pkg::REG_GRAVITY:       r_cfg.gravity       <= i_cfg_data[7:0];
                bphm_pkg::REG_ORIGIN_X:      r_cfg.origin_x      <= i_cfg_data[11:0];
                bphm_pkg::REG_BASELINE_Y:    r_cfg.baseline_y    <= i_cfg_data[11:0];
                bphm_pkg::REG_BAND_PITCH:    r_cfg.band_pitch    <= i_cfg_data[7:0];
                bphm_pkg::REG_FULL_HEIGHT:   r_cfg.full_height   <= i_cfg_data[9:0];
                bphm_pkg::REG_MARKER_HEIGHT: r_cfg.marker_height <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bphm_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_vld       (s_axis_tvalid),
        .i_band      (s_axis_tdata[5:0]),
        .i_level     (s_axis_tdata[21:6]),
        .o_ready     (s_axis_tready),
        .i_nxt_ready (geom_ready),
        .o_vld       (trk_vld),
        .o_trk       (trk)
    );

    bphm_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_vld       (trk_vld),
        .i_trk       (trk),
        .o_ready     (geom_ready),
        .i_out_ready (m_axis_tready),
        .o_vld       (m_axis_tvalid),
        .o_res       (res)
    );

    assign m_axis_tdata = {7'd0, res.peak_level, res.marker_top, res.bar_height,
                           res.bar_top, res.box_x, res.band_out};
    assign m_axis_tuser = {res.draw_marker, res.draw_bar};

    // Marker is never drawn without its bar.
    `BPHM_ASSERT(a_marker_needs_bar, i_clk, i_rst_n,
        m_axis_tvalid |-> (!res.draw_marker || res.draw_bar))
    // Out-of-range bands report no peak and no drawing.
    `BPHM_ASSERT(a_oob_band_quiet, i_clk, i_rst_n,
        (m_axis_tvalid && ({1'b0, res.band_out} >= (bphm_pkg::BAND_W + 1)'(bphm_pkg::NUM_BANDS)))
        |-> (res.peak_level == '0 && !res.draw_bar))
    // Input is only held off when the output side is backed up.
    `BPHM_ASSERT(a_ready_only_on_stall, i_clk, i_rst_n,
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    // The pipeline comes out of reset empty.
    `BPHM_ASSERT_ALWAYS(a_empty_after_reset, i_clk,
        !$past(i_rst_n) |-> !m_axis_tvalid)

endmodule

// ===== tb/tb_band_peak_hold_meter.sv =====
// Self-checking bench for band_peak_hold_meter: directed table, then random phases.
`timescale 1ns / 1ps

module tb_band_peak_hold_meter;
    import bphm_pkg::*;

    localparam int STALL_MAX    = 19;
    localparam int QUIET_LIMIT  = 500;   // cycles with no transaction at all
    localparam int RAND_ITEMS   = 500;
    localparam int RAND_PHASES  = 8;
    localparam int DRAIN_CYCLES = 8;     // pipeline is four deep

    typedef enum logic {ROW_LEVEL, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [BAND_W-1:0]      band;
        logic [LEVEL_W-1:0]     level;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        bit                     known;    // res typed in by hand
        t_res                   res;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [23:0]            s_axis_tdata = '0;   // band[5:0], level[21:6], zero pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // band_out[5:0], box_x[20:6], bar_top[33:21], bar_height[43:34],
    // marker_top[56:44], peak_level[72:57], zero pad[79:73]
    logic [79:0]            m_axis_tdata;
    logic [1:0]             m_axis_tuser;        // draw_bar[0], draw_marker[1]

    band_peak_hold_meter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the meter: register file and per-band stores.
    t_cfg               cfg_shadow;
    logic [LEVEL_W-1:0] peak_mem [NUM_BANDS];
    logic [HOLD_W-1:0]  hold_mem [NUM_BANDS];
    logic [FALL_W-1:0]  fall_mem [NUM_BANDS];

    t_res       due_readings [$];   // readings accepted in, not yet out
    t_stim_row  dir_rows [$];
    int         err_count = 0;
    int         quiet_cycles = 0;
    bit         gaps_on = 1'b1;

    // Bar height for a level: clamp to full scale, then scale.
    function automatic int height_of(input int v);
        int c;
        c = (v > FULL_SCALE) ? FULL_SCALE : v;
        return (int'(cfg_shadow.full_height) * c) / FULL_SCALE;
    endfunction

    // Peak hold / gravity fall for one band level, then the box geometry.
    function automatic t_res meter_update(input logic [BAND_W-1:0] band,
                                          input logic [LEVEL_W-1:0] level);
        t_res r;
        int   lvl, pk, hold, fall, dropped, pk_out, bar_h;
        bit   in_range;
        lvl      = int'(level);
        in_range = int'(band) < NUM_BANDS;
        pk_out   = 0;
        if (in_range) begin
            pk   = int'(peak_mem[band]);
            hold = int'(hold_mem[band]);
            fall = int'(fall_mem[band]);
            if (lvl > pk) begin
                pk   = lvl;
                hold = int'(cfg_shadow.hold_time);
                fall = 0;
            end
            if (hold > 0) begin
                hold--;
            end else begin
                // compared signed: a peak dropping under zero snaps too
                dropped = pk - fall;
                if (dropped < lvl) begin
                    pk   = lvl;
                    fall = 0;
                    hold = int'(cfg_shadow.hold_time);
                end else begin
                    pk   = dropped;
                    fall = fall + int'(cfg_shadow.gravity);
                    if (fall > 65535) fall = 65535;
                end
            end
            peak_mem[band] = LEVEL_W'(pk);
            hold_mem[band] = HOLD_W'(hold);
            fall_mem[band] = FALL_W'(fall);
            pk_out = pk;
        end
        bar_h = height_of(lvl);
        r.band_out    = band;
        r.box_x       = BOX_X_W'(int'(cfg_shadow.origin_x)
                                 + int'(cfg_shadow.band_pitch) * int'(band));
        r.bar_height  = HEIGHT_W'(bar_h);
        r.bar_top     = TOP_W'(int'(cfg_shadow.baseline_y) - bar_h);
        r.marker_top  = TOP_W'(int'(cfg_shadow.baseline_y) - height_of(pk_out)
                               - int'(cfg_shadow.marker_height));
        r.peak_level  = LEVEL_W'(pk_out);
        r.draw_bar    = in_range && (cfg_shadow.print_mode != PM_NONE);
        r.draw_marker = in_range && (cfg_shadow.print_mode >= PM_ALL);
        return r;
    endfunction

    function automatic t_stim_row item_row(input logic [BAND_W-1:0] band,
                                           input logic [LEVEL_W-1:0] level);
        t_stim_row row;
        row          = '{kind: ROW_LEVEL, default: '0};
        row.kind     = ROW_LEVEL;
        row.band     = band;
        row.level    = level;
        row.known    = 1'b0;
        return row;
    endfunction

    function automatic t_stim_row known_row(input logic [BAND_W-1:0] band,
                                            input logic [LEVEL_W-1:0] level,
                                            input int box_x, input int bar_top,
                                            input int bar_h, input int mark_top,
                                            input int peak, input bit db, input bit dm);
        t_stim_row row;
        row = item_row(band, level);
        row.known              = 1'b1;
        row.res.band_out       = band;
        row.res.box_x          = BOX_X_W'(box_x);
        row.res.bar_top        = TOP_W'(bar_top);
        row.res.bar_height     = HEIGHT_W'(bar_h);
        row.res.marker_top     = TOP_W'(mark_top);
        row.res.peak_level     = LEVEL_W'(peak);
        row.res.draw_bar       = db;
        row.res.draw_marker    = dm;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row          = '{kind: ROW_REG, default: '0};
        row.kind     = ROW_REG;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic check_reading(input t_res got);
        t_res want;
        if (due_readings.size() == 0) begin
            flag_mismatch("reading with nothing pending, band", got.band_out, '0);
            return;
        end
        want = due_readings.pop_front();
        if (got.band_out !== want.band_out)
            flag_mismatch("band_out", got.band_out, want.band_out);
        if (got.box_x !== want.box_x)
            flag_mismatch("box_x", got.box_x, want.box_x);
        if (got.bar_top !== want.bar_top)
            flag_mismatch("bar_top", got.bar_top, want.bar_top);
        if (got.bar_height !== want.bar_height)
            flag_mismatch("bar_height", got.bar_height, want.bar_height);
        if (got.marker_top !== want.marker_top)
            flag_mismatch("marker_top", got.marker_top, want.marker_top);
        if (got.peak_level !== want.peak_level)
            flag_mismatch("peak_level", got.peak_level, want.peak_level);
        if (got.draw_bar !== want.draw_bar)
            flag_mismatch("draw_bar", got.draw_bar, want.draw_bar);
        if (got.draw_marker !== want.draw_marker)
            flag_mismatch("draw_marker", got.draw_marker, want.draw_marker);
    endtask

    // Drop the input stream and wait for every pending reading to come out.
    // Always waits for a later falling edge so tvalid is not driven twice in a step.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (due_readings.size() != 0);
    endtask

    // One register write; the first of a burst waits for the pipeline to empty.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (!i_cfg_we) wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_PRINT_MODE:    cfg_shadow.print_mode    = data[1:0];
            REG_HOLD_TIME:     cfg_shadow.hold_time     = data[7:0];
            REG_GRAVITY:       cfg_shadow.gravity       = data[7:0];
            REG_ORIGIN_X:      cfg_shadow.origin_x      = data[11:0];
            REG_BASELINE_Y:    cfg_shadow.baseline_y    = data[11:0];
            REG_BAND_PITCH:    cfg_shadow.band_pitch    = data[7:0];
            REG_FULL_HEIGHT:   cfg_shadow.full_height   = data[9:0];
            REG_MARKER_HEIGHT: cfg_shadow.marker_height = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Send one band level; called and returning on a falling edge.
    // tvalid is left high so a back-to-back transaction needs no toggle.
    task automatic push_level(input logic [BAND_W-1:0] band,
                              input logic [LEVEL_W-1:0] level,
                              input bit known, input t_res typed);
        int   gap;
        t_res predicted;
        gap = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
        i_cfg_we <= 1'b0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, level, band};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = meter_update(band, level);
        due_readings.push_back(known ? typed : predicted);
        @(negedge i_clk);
    endtask

    // Result side: sample on the rising edge.
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.band_out    = m_axis_tdata[5:0];
            got.box_x       = m_axis_tdata[20:6];
            got.bar_top     = m_axis_tdata[33:21];
            got.bar_height  = m_axis_tdata[43:34];
            got.marker_top  = m_axis_tdata[56:44];
            got.peak_level  = m_axis_tdata[72:57];
            got.draw_bar    = m_axis_tuser[0];
            got.draw_marker = m_axis_tuser[1];
            check_reading(got);
        end
    end

    // Receiver stalls: a fresh wait drawn for every transaction.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = gaps_on ? $urandom_range(0, STALL_MAX) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Watchdog: any long stretch without a transaction means the block hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_band_peak_hold_meter: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_stim_row              row;
        t_res                   no_res;
        int                     span;
        logic [BAND_W-1:0]      band;
        logic [LEVEL_W-1:0]     lvl;
        logic [CFG_DATA_W-1:0]  raw;

        no_res     = '0;
        cfg_shadow = CFG_RESET;
        for (int b = 0; b < NUM_BANDS; b++) begin
            peak_mem[b] = '0;
            hold_mem[b] = '0;
            fall_mem[b] = '0;
        end

        // Reset defaults: mode 2, hold 15, gravity 1, origin 0, baseline 600,
        // pitch 5, full height 60, marker 2.
        dir_rows.push_back(known_row(0, 0, 0, 600, 0, 598, 0, 1, 1));
        dir_rows.push_back(known_row(1, 100, 5, 540, 60, 538, 100, 1, 1));
        dir_rows.push_back(known_row(2, 16'hFFFF, 10, 540, 60, 538, 65535, 1, 1));
        // bands past the store: zero peak, nothing drawn
        dir_rows.push_back(known_row(16, 100, 80, 540, 60, 598, 0, 0, 0));
        dir_rows.push_back(known_row(63, 16'hFFFF, 315, 540, 60, 598, 0, 0, 0));
        dir_rows.push_back(known_row(15, 50, 75, 570, 30, 568, 50, 1, 1));
        dir_rows.push_back(known_row(3, 1, 15, 600, 0, 598, 1, 1, 1));
        dir_rows.push_back(known_row(4, 99, 20, 541, 59, 539, 99, 1, 1));
        dir_rows.push_back(known_row(5, 101, 25, 540, 60, 538, 101, 1, 1));
        // hold countdown, equal level does not reload
        dir_rows.push_back(item_row(1, 0));
        dir_rows.push_back(item_row(1, 100));
        // mode three, zero hold falls at once, heavy gravity drives peak below zero
        dir_rows.push_back(reg_row(REG_PRINT_MODE, 12'd3));
        dir_rows.push_back(reg_row(REG_HOLD_TIME, 12'd0));
        dir_rows.push_back(reg_row(REG_GRAVITY, 12'd255));
        dir_rows.push_back(item_row(6, 1000));
        dir_rows.push_back(item_row(6, 0));
        dir_rows.push_back(item_row(6, 0));
        dir_rows.push_back(item_row(6, 0));
        dir_rows.push_back(item_row(6, 0));
        // bars only, then nothing drawn
        dir_rows.push_back(reg_row(REG_PRINT_MODE, {10'd0, PM_BARS}));
        dir_rows.push_back(item_row(7, 40));
        dir_rows.push_back(reg_row(REG_PRINT_MODE, {10'd0, PM_NONE}));
        dir_rows.push_back(item_row(7, 40));
        // geometry at its extremes, negative tops
        dir_rows.push_back(reg_row(REG_ORIGIN_X, 12'hFFF));
        dir_rows.push_back(reg_row(REG_BASELINE_Y, 12'd0));
        dir_rows.push_back(reg_row(REG_BAND_PITCH, 12'hFF));
        dir_rows.push_back(reg_row(REG_FULL_HEIGHT, 12'h3FF));
        dir_rows.push_back(reg_row(REG_MARKER_HEIGHT, 12'hFF));
        dir_rows.push_back(reg_row(REG_PRINT_MODE, {10'd0, PM_ALL}));
        dir_rows.push_back(known_row(63, 16'hFFFF, 20160, -1023, 1023, -255, 0, 0, 0));
        dir_rows.push_back(item_row(15, 16'hFFFF));
        dir_rows.push_back(item_row(0, 16'hFFFF));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_REG)
                cfg_write(row.reg_idx, row.reg_data);
            else
                push_level(row.band, row.level, row.known, row.res);
        end

        // Random phases: all-zero and all-ones settings first, then random ones.
        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int r = 0; r < 8; r++) begin
                if (p == 0)
                    raw = '0;
                else if (p == 1)
                    raw = '1;
                else if (CFG_IDX_W'(r) == REG_HOLD_TIME)
                    raw = {4'($urandom), 8'($urandom_range(0, 12))};   // short holds fall more
                else
                    raw = CFG_DATA_W'($urandom);
                cfg_write(CFG_IDX_W'(r), raw);
            end
            gaps_on = (p % 3) != 2;
            // few bands per frame on odd phases, so each band sees long histories
            span = (p % 2) ? 4 : NUM_BANDS;
            for (int k = 0; k < RAND_ITEMS / RAND_PHASES; k++) begin
                if ($urandom_range(0, 9) < 8)
                    band = BAND_W'(k % span);
                else
                    band = BAND_W'($urandom_range(0, 63));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: lvl = LEVEL_W'($urandom_range(0, 40));
                    5, 6:          lvl = LEVEL_W'($urandom_range(0, 120));
                    7:             lvl = '0;
                    8:             lvl = LEVEL_W'($urandom);
                    default:       lvl = LEVEL_W'(FULL_SCALE);
                endcase
                push_level(band, lvl, 1'b0, no_res);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_band_peak_hold_meter: clean");
        end else begin
            $display("tb_band_peak_hold_meter: errors");
        end
        $finish;
    end

endmodule

// ===== band_peak_hold_meter.f =====
+incdir+hw/rtl
hw/rtl/bphm_pkg.sv
hw/rtl/bphm_track.sv
hw/rtl/bphm_geom.sv
hw/rtl/band_peak_hold_meter.sv
tb/tb_band_peak_hold_meter.sv
